// ===== rtl/core/wfgd_pkg.sv =====
package wfgd_pkg;

  // default sizing
  localparam int unsigned TASKS_DEF     = 4;
  localparam int unsigned RESOURCES_DEF = 3;

  // fixed field widths
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned MASK_W = 3;
  localparam int unsigned LOOP_W = 2;

  // queue depths
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // action codes on the input
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // node colors during the search
  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GRAY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_EVAL,
    OP_DROP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_STEP,
    ST_SCAN,
    ST_CLOSE,
    ST_SAFE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] held;
    logic [MASK_W-1:0] wanted;
  } cmd_t;

  typedef struct packed {
    logic              deadlock;
    logic [LOOP_W-1:0] loop_task;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/wfgd_fifo.sv =====
module wfgd_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic [0:0]
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/wfgd_front.sv =====
module wfgd_front #(
  parameter int unsigned TASKS = wfgd_pkg::TASKS_DEF,
  parameter int unsigned DEPTH = wfgd_pkg::CMD_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [wfgd_pkg::IDX_W-1:0]  task_index_i,
  input  logic [wfgd_pkg::MASK_W-1:0] held_mask_i,
  input  logic [wfgd_pkg::MASK_W-1:0] wanted_mask_i,
  output logic                        cmd_valid_o,
  output wfgd_pkg::cmd_t              cmd_o,
  input  logic                        cmd_pop_i
);

  import wfgd_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;
  logic keep;

  // classify: loads to a task that does not exist are dropped here
  always_comb begin
    cmd_in.idx    = task_index_i;
    cmd_in.held   = held_mask_i;
    cmd_in.wanted = wanted_mask_i;
    case (action_i)
      ACT_LOAD: cmd_in.op = (32'(task_index_i) < TASKS) ? OP_LOAD : OP_DROP;
      ACT_EVAL: cmd_in.op = OP_EVAL;
      default:  cmd_in.op = OP_DROP;
    endcase
  end

  assign keep        = push && (cmd_in.op != OP_DROP);
  assign cmd_valid_o = !cmd_empty;

  wfgd_fifo #(
    .DEPTH (DEPTH),
    .T     (cmd_t)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (keep),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

endmodule

// ===== rtl/core/wfgd_engine.sv =====
module wfgd_engine #(
  parameter int unsigned TASKS     = wfgd_pkg::TASKS_DEF,
  parameter int unsigned RESOURCES = wfgd_pkg::RESOURCES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  wfgd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_push_o,
  output wfgd_pkg::res_t res_o,
  input  logic           res_full_i
);

  import wfgd_pkg::*;

  localparam int unsigned TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned DW = $clog2(TASKS + 1);

  state_e state_q, state_d;

  logic [RESOURCES-1:0] held_q   [TASKS];
  logic [RESOURCES-1:0] wanted_q [TASKS];
  logic [1:0]           color_q  [TASKS];
  logic [TW-1:0]        stack_q  [TASKS];
  logic [DW-1:0]        cursor_q [TASKS];
  logic [DW-1:0]        depth_q;
  logic [DW-1:0]        root_q;
  logic [TW-1:0]        target_q;
  logic [TW-1:0]        scan_q;
  logic                 started_q;

  logic [DW-1:0] depth_m1;
  logic [TW-1:0] top_idx, node, cur_idx, root_idx, push_idx, load_idx, scan_task;
  logic [DW-1:0] cur;
  logic          cur_end, edge_hit, root_end, depth_full, scan_hit, scan_at_top;
  logic [1:0]    cur_color, root_color;
  logic          take_load, take_eval;

  assign depth_m1    = depth_q - DW'(1);
  assign top_idx     = depth_m1[TW-1:0];
  assign node        = stack_q[top_idx];
  assign cur         = cursor_q[top_idx];
  assign cur_end     = (cur == DW'(TASKS));
  assign cur_idx     = cur[TW-1:0];
  assign edge_hit    = |(wanted_q[node] & held_q[cur_idx]);
  assign cur_color   = color_q[cur_idx];
  assign root_idx    = root_q[TW-1:0];
  assign root_end    = (root_q == DW'(TASKS));
  assign root_color  = color_q[root_idx];
  assign depth_full  = (depth_q == DW'(TASKS));
  assign push_idx    = depth_q[TW-1:0];
  assign scan_task   = stack_q[scan_q];
  assign scan_hit    = started_q || (scan_task == target_q);
  assign scan_at_top = (DW'(scan_q) == depth_m1);
  assign load_idx    = TW'(cmd_i.idx);
  assign take_load   = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_LOAD);
  assign take_eval   = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_EVAL);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_eval) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_end) begin
          state_d = ST_SAFE;
        end else if (root_color == COL_WHITE) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (depth_q == '0) begin
          state_d = ST_ROOT;
        end else if (!cur_end && edge_hit && (cur_color == COL_GRAY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit && !res_full_i && scan_at_top) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE, ST_SAFE: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      ST_SCAN: begin
        res_push_o      = scan_hit && !res_full_i;
        res_o.deadlock  = 1'b1;
        res_o.loop_task = LOOP_W'(scan_task);
      end
      ST_CLOSE: begin
        res_push_o      = !res_full_i;
        res_o.deadlock  = 1'b1;
        res_o.loop_task = LOOP_W'(target_q);
        res_o.last      = 1'b1;
      end
      ST_SAFE: begin
        res_push_o = !res_full_i;
        res_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      depth_q   <= '0;
      root_q    <= '0;
      started_q <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        held_q[i]   <= '0;
        wanted_q[i] <= '0;
        color_q[i]  <= COL_WHITE;
      end
    end else begin
      state_q <= state_d;
      if (take_load) begin
        held_q[load_idx]   <= RESOURCES'(cmd_i.held);
        wanted_q[load_idx] <= RESOURCES'(cmd_i.wanted);
      end
      if (take_eval) begin
        root_q  <= '0;
        depth_q <= '0;
        for (int i = 0; i < TASKS; i++) begin
          color_q[i] <= COL_WHITE;
        end
      end
      case (state_q)
        ST_ROOT: begin
          if (!root_end) begin
            root_q <= root_q + DW'(1);
            if (root_color == COL_WHITE) begin
              color_q[root_idx] <= COL_GRAY;
              depth_q           <= DW'(1);
            end
          end
        end
        ST_STEP: begin
          if (depth_q != '0) begin
            if (cur_end) begin
              color_q[node] <= COL_BLACK;
              depth_q       <= depth_m1;
            end else if (edge_hit) begin
              if ((cur_color == COL_WHITE) && !depth_full) begin
                color_q[cur_idx] <= COL_GRAY;
                depth_q          <= depth_q + DW'(1);
              end else if (cur_color == COL_GRAY) begin
                started_q <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit && !res_full_i) begin
            started_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // path stack, cursors and cycle walk
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ROOT: begin
        if (!root_end && (root_color == COL_WHITE)) begin
          stack_q[0]  <= root_idx;
          cursor_q[0] <= '0;
        end
      end
      ST_STEP: begin
        if ((depth_q != '0) && !cur_end) begin
          cursor_q[top_idx] <= cur + DW'(1);
          if (edge_hit) begin
            if ((cur_color == COL_WHITE) && !depth_full) begin
              stack_q[push_idx]  <= cur_idx;
              cursor_q[push_idx] <= '0;
            end else if (cur_color == COL_GRAY) begin
              target_q <= cur_idx;
              scan_q   <= '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!scan_hit || !res_full_i) begin
          scan_q <= scan_q + TW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/wait_for_graph_deadlock_detector.sv =====
// channel   handshake             payload
// -------   -------------------   ----------------------------------------------
// input     push / full           action_i, task_index_i, held_mask_i, wanted_mask_i
// result    empty / pop           deadlock_o, loop_task_o, last_o
//
// a load item is taken while the engine is idle and gives no result
// a safe evaluate item is taken, then steps through root probes, edge checks,
// retired nodes and finished trees before its verdict; a deadlock ends the search early
// with one result per path entry from the gray task up, then one for the closer
// reset clears the held and wanted rows, both queues and the engine state
// a full result queue stalls the engine; a full command queue raises full
module wait_for_graph_deadlock_detector #(
  parameter int unsigned TASKS     = wfgd_pkg::TASKS_DEF,
  parameter int unsigned RESOURCES = wfgd_pkg::RESOURCES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [wfgd_pkg::IDX_W-1:0]  task_index_i,
  input  logic [wfgd_pkg::MASK_W-1:0] held_mask_i,
  input  logic [wfgd_pkg::MASK_W-1:0] wanted_mask_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        deadlock_o,
  output logic [wfgd_pkg::LOOP_W-1:0] loop_task_o,
  output logic                        last_o
);

  import wfgd_pkg::*;

  // front to engine: decoded commands
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // engine to result queue
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  // front: classifies items, drops loads to missing tasks, buffers commands
  wfgd_front #(
    .TASKS (TASKS),
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .task_index_i  (task_index_i),
    .held_mask_i   (held_mask_i),
    .wanted_mask_i (wanted_mask_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back: row storage and the depth-first cycle search
  wfgd_engine #(
    .TASKS     (TASKS),
    .RESOURCES (RESOURCES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // results wait here until popped, so the engine can run ahead
  wfgd_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (res_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign deadlock_o  = res_out.deadlock;
  assign loop_task_o = res_out.loop_task;
  assign last_o      = res_out.last;

endmodule

// ===== rtl/core/wfgd_checker.sv =====
module wfgd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic                        deadlock_o,
  input logic [wfgd_pkg::LOOP_W-1:0] loop_task_o,
  input logic                        last_o
);

  // both queues come out of reset empty
  a_reset_clear : assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not clear in reset");

  // a safe verdict is a single closing result with no task
  a_safe_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !deadlock_o) |-> ((loop_task_o == '0) && last_o))
    else $error("malformed safe result");

  // only cycle members come before the closing result
  a_mid_is_loop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> deadlock_o)
    else $error("non-final result without deadlock");

  // a waiting result holds until taken
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable({deadlock_o, loop_task_o, last_o})))
    else $error("result changed while stalled");

endmodule

bind wait_for_graph_deadlock_detector wfgd_checker u_chk (.*);

// ===== bench/deadlock_report_checker.sv =====
module deadlock_report_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic                        full,
  input  logic                        action_i,
  input  logic [wfgd_pkg::IDX_W-1:0]  task_index_i,
  input  logic [wfgd_pkg::MASK_W-1:0] held_mask_i,
  input  logic [wfgd_pkg::MASK_W-1:0] wanted_mask_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        deadlock_o,
  input  logic [wfgd_pkg::LOOP_W-1:0] loop_task_o,
  input  logic                        last_o,
  output int                          mismatches,
  output int                          awaited,
  output int                          results_checked,
  output int                          deadlock_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  import wfgd_pkg::*;

  localparam int NT = TASKS_DEF;
  localparam logic [MASK_W-1:0] RES_KEEP = MASK_W'((1 << RESOURCES_DEF) - 1);

  logic [MASK_W-1:0] held_rows   [NT] = '{default: '0};
  logic [MASK_W-1:0] wanted_rows [NT] = '{default: '0};
  res_t              expected_loop [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void add_expect(input logic dl, input int t, input logic fin);
    res_t r;
    r.deadlock  = dl;
    r.loop_task = LOOP_W'(t);
    r.last      = fin;
    expected_loop.push_back(r);
  endfunction

  // wait-for graph, then colored depth-first search in ascending order
  function automatic void predict_cycle_report();
    logic [NT-1:0] waits_on [NT];
    logic [1:0]    mark     [NT];
    int            trail    [NT];
    int            probe    [NT];
    int            len;
    int            node;
    int            peer;
    int            first;
    bit            closed;
    closed = 1'b0;
    len    = 0;
    for (int a = 0; a < NT; a++) begin
      waits_on[a] = '0;
      mark[a]     = COL_WHITE;
      for (int b = 0; b < NT; b++) begin
        if ((wanted_rows[a] & held_rows[b]) != '0) waits_on[a][b] = 1'b1;
      end
    end
    for (int root = 0; root < NT && !closed; root++) begin
      if (mark[root] != COL_WHITE) continue;
      mark[root] = COL_GRAY;
      trail[0]   = root;
      probe[0]   = 0;
      len        = 1;
      while (len > 0 && !closed) begin
        node = trail[len-1];
        peer = probe[len-1];
        if (peer >= NT) begin
          mark[node] = COL_BLACK;
          len--;
        end else begin
          probe[len-1] = peer + 1;
          if (waits_on[node][peer]) begin
            if (mark[peer] == COL_WHITE) begin
              if (len < NT) begin
                mark[peer] = COL_GRAY;
                trail[len] = peer;
                probe[len] = 0;
                len++;
              end
            end else if (mark[peer] == COL_GRAY) begin
              // back edge: path from the gray ancestor down, then it again
              first = 0;
              while (first < len && trail[first] != peer) first++;
              for (int k = first; k < len; k++) add_expect(1'b1, trail[k], 1'b0);
              add_expect(1'b1, peer, 1'b1);
              closed = 1'b1;
            end
          end
        end
      end
    end
    if (!closed) add_expect(1'b0, 0, 1'b1);
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (push && !full) begin
        if (action_i == ACT_EVAL) begin
          predict_cycle_report();
        end else if (int'(task_index_i) < NT) begin
          held_rows[task_index_i]   = held_mask_i & RES_KEEP;
          wanted_rows[task_index_i] = wanted_mask_i & RES_KEEP;
        end
      end
      if (pop && !empty) begin
        results_checked++;
        if (deadlock_o && last_o) deadlock_reports++;
        if (expected_loop.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_checked));
        end else begin
          want = expected_loop.pop_front();
          if (deadlock_o !== want.deadlock)
            report_mismatch($sformatf("result %0d deadlock %b, expected %b",
                                      results_checked, deadlock_o, want.deadlock));
          if (loop_task_o !== want.loop_task)
            report_mismatch($sformatf("result %0d loop_task %0d, expected %0d",
                                      results_checked, loop_task_o, want.loop_task));
          if (last_o !== want.last)
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      results_checked, last_o, want.last));
        end
      end
      awaited = expected_loop.size();
    end
  end

endmodule

// ===== bench/wait_for_graph_deadlock_detector_tb.sv =====
module wait_for_graph_deadlock_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfgd_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic              action_i;
  logic [IDX_W-1:0]  task_index_i;
  logic [MASK_W-1:0] held_mask_i;
  logic [MASK_W-1:0] wanted_mask_i;
  logic              empty;
  logic              pop;
  logic              deadlock_o;
  logic [LOOP_W-1:0] loop_task_o;
  logic              last_o;

  // verdict inputs from the checker
  int mismatches;
  int awaited;
  int results_checked;
  int deadlock_reports;

  // stimulus bookkeeping
  int items_sent;
  int evals_sent;
  int pause_pct;
  bit calm;       // last stretch: no idling on either side
  bit hold_req;   // ask the result side for one long stall
  bit hold_done;

  wait_for_graph_deadlock_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .task_index_i  (task_index_i),
    .held_mask_i   (held_mask_i),
    .wanted_mask_i (wanted_mask_i),
    .empty         (empty),
    .pop           (pop),
    .deadlock_o    (deadlock_o),
    .loop_task_o   (loop_task_o),
    .last_o        (last_o)
  );

  deadlock_report_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .task_index_i     (task_index_i),
    .held_mask_i      (held_mask_i),
    .wanted_mask_i    (wanted_mask_i),
    .empty            (empty),
    .pop              (pop),
    .deadlock_o       (deadlock_o),
    .loop_task_o      (loop_task_o),
    .last_o           (last_o),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .results_checked  (results_checked),
    .deadlock_reports (deadlock_reports)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // present one item and hold it until an edge with full low takes it
  task automatic offer(input logic act, input logic [IDX_W-1:0] t,
                       input logic [MASK_W-1:0] h, input logic [MASK_W-1:0] w);
    push          <= 1'b1;
    action_i      <= act;
    task_index_i  <= t;
    held_mask_i   <= h;
    wanted_mask_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (act == ACT_EVAL) evals_sent++;
  endtask

  // random gap on the input side, skipped in the calm stretch
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 99) < pause_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // mostly single-resource masks so that safe graphs stay common
  function automatic logic [MASK_W-1:0] sparse_mask();
    if ($urandom_range(0, 2) == 0) return MASK_W'($urandom_range(0, 7));
    return MASK_W'(1 << $urandom_range(0, 2));
  endfunction

  // random don't-care fields on evaluate items
  task automatic offer_eval();
    offer(ACT_EVAL, IDX_W'($urandom_range(0, 3)), MASK_W'($urandom_range(0, 7)),
          MASK_W'($urandom_range(0, 7)));
  endtask

  // result side: random pop bursts, one long stall on request, steady at the end
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (calm) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    action_i      = ACT_LOAD;
    task_index_i  = '0;
    held_mask_i   = '0;
    wanted_mask_i = '0;
    items_sent    = 0;
    evals_sent    = 0;
    pause_pct     = 30;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all rows clear after reset: safe
    offer_eval();
    sender_pause();
    // task 0 waits on a resource it holds itself
    offer(ACT_LOAD, 2'd0, 3'b001, 3'b001);
    offer_eval();
    sender_pause();
    // three-task ring 0 -> 1 -> 2 -> 0
    offer(ACT_LOAD, 2'd0, 3'b001, 3'b010);
    offer(ACT_LOAD, 2'd1, 3'b010, 3'b100);
    offer(ACT_LOAD, 2'd2, 3'b100, 3'b001);
    offer_eval();
    sender_pause();
    // task 3 wants everything but holds nothing
    offer(ACT_LOAD, 2'd3, 3'b000, 3'b111);
    offer_eval();
    // every task holds and wants every resource
    for (int t = 0; t < 4; t++) offer(ACT_LOAD, IDX_W'(t), 3'b111, 3'b111);
    offer_eval();
    sender_pause();
    // everything released: safe again
    for (int t = 0; t < 4; t++) offer(ACT_LOAD, IDX_W'(t), 3'b000, 3'b000);
    offer_eval();
    // highest task number in a self wait
    offer(ACT_LOAD, 2'd3, 3'b100, 3'b100);
    offer_eval();

    // back-pressure: results stall for a long stretch while evaluations keep coming
    hold_req = 1'b1;
    repeat (10) offer_eval();
    sender_pause();

    // random part: mostly load groups followed by an evaluation, some loose noise
    while (items_sent < 410) begin
      if (items_sent >= 350) calm = 1'b1;
      pause_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      if ($urandom_range(0, 6) == 0) begin
        offer(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 3)),
              MASK_W'($urandom_range(0, 7)), MASK_W'($urandom_range(0, 7)));
        sender_pause();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          offer(ACT_LOAD, IDX_W'($urandom_range(0, 3)), sparse_mask(),
                ($urandom_range(0, 2) == 0) ? MASK_W'(0) : sparse_mask());
          sender_pause();
        end
        offer_eval();
        sender_pause();
      end
    end

    // drain: wait for every expected result, then a few search times more
    push <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("covered %0d items with %0d evaluations, %0d results checked",
             items_sent, evals_sent, results_checked);
    $display("%0d evaluations reported a circular wait, one long result stall included",
             deadlock_reports);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wfgd_pkg.sv
rtl/core/wfgd_fifo.sv
rtl/core/wfgd_front.sv
rtl/core/wfgd_engine.sv
rtl/core/wait_for_graph_deadlock_detector.sv
rtl/core/wfgd_checker.sv
bench/deadlock_report_checker.sv
bench/wait_for_graph_deadlock_detector_tb.sv
